// ===== design/cbb_pkg.sv =====
// package for the circuit breaker with rolling window and backoff
// types, request codes, register indexes and saturating helpers
// no dependencies
`timescale 1ns / 1ps

package cbb_pkg;

  localparam logic [2:0] REQ_TIME    = 3'd0;
  localparam logic [2:0] REQ_SUCCESS = 3'd1;
  localparam logic [2:0] REQ_FAILURE = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_RESET   = 3'd4;

  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_INIT_INTV = 3'd1;
  localparam logic [2:0] CFG_MULT      = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd3;
  localparam logic [2:0] CFG_PERIOD    = 3'd4;

  localparam logic [1:0] ST_CLOSED    = 2'd0;
  localparam logic [1:0] ST_OPEN      = 2'd1;
  localparam logic [1:0] ST_HALF_OPEN = 2'd2;

  localparam logic [18:0] SUM_MAX = 19'h7FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] elapsed_ms;
  } cbb_in_t;

  typedef struct packed {
    logic [1:0]  state_code;
    logic        ready_res;
    logic [18:0] failure_total;
    logic [18:0] success_total;
    logic [15:0] consecutive_failures;
    logic        is_tripped;
  } cbb_out_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_PRE,
    SQ_EVAL,
    SQ_ROTCHK,
    SQ_ROT,
    SQ_RD,
    SQ_WR,
    SQ_SUM,
    SQ_TAIL,
    SQ_DONE
  } cbb_seq_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_mul32(input logic [31:0] a, input logic [4:0] b);
    logic [36:0] p;
    p = {5'd0, a} * {32'd0, b};
    return (p[36:32] != 5'd0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

endpackage

// ===== design/cbb_bucket_mem.sv =====
// bucket ring storage: packed success and failure counts per bucket
// synchronous memory with registered read and per-entry valid bits
// depends on nothing but its parameters
`timescale 1ns / 1ps

module cbb_bucket_mem #(
  parameter int NUM_BUCKETS = 8,
  parameter int DW = 32,
  parameter int IW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear_all,
  input  logic          inval_en,
  input  logic [IW-1:0] inval_addr,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [IW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]          mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid_r;
  logic [DW-1:0]          rd_raw_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (clear_all) begin
        valid_r <= '0;
      end else begin
        if (inval_en) valid_r[inval_addr] <= 1'b0;
        if (wr_en) valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ===== design/circuit_breaker_backoff.sv =====
// circuit breaker top level: timers, backoff, sequencer and window sums (cbb_pkg, cbb_bucket_mem)
// one transaction at a time: in_stall holds off new requests until the sequencer is idle again,
// since every transaction walks all buckets of the memory through its single read port;
// a success or failure may first rotate the ring, one bucket per elapsed period, and
// out_stall holds the finished result in the done state
// synchronous active-low reset; bucket valid bits clear at once
`timescale 1ns / 1ps

module circuit_breaker_backoff #(
  parameter int NUM_BUCKETS = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cbb_pkg::cbb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cbb_pkg::cbb_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import cbb_pkg::*;

  localparam int IW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNTW = $clog2(NUM_BUCKETS + 1);
  localparam int DW   = 2 * COUNT_WIDTH;
  localparam int AW   = COUNT_WIDTH + IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUCKETS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [15:0] thr_r, init_r, period_r;
  logic [4:0]  mult_r;
  logic [31:0] timeout_r;

  cbb_seq_t    state_r, state_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] tsa_r, tsa_nxt, tsf_r, tsf_nxt, tsbs_r, tsbs_nxt;
  logic [31:0] intv_r, intv_nxt;
  logic        stopped_r, stopped_nxt, tripped_r, tripped_nxt, hot_r, hot_nxt;
  logic [15:0] cfc_r, cfc_nxt;
  logic [IW-1:0] cb_r, cb_nxt, idx_r, idx_nxt;
  logic [31:0] gap_r, gap_nxt;
  logic [CNTW-1:0] rot_cnt_r, rot_cnt_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        ready_r, ready_nxt;
  logic        acc_en_r, acc_en_nxt;
  logic [AW-1:0] fs_acc_r, fs_acc_nxt, ss_acc_r, ss_acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  cbb_out_t    out_data_r, out_data_nxt;

  logic          mem_clear, mem_inval, mem_we;
  logic [IW-1:0] mem_inval_addr, mem_rd_addr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [COUNT_WIDTH-1:0] rd_fail, rd_succ;
  logic [IW-1:0] cb_inc;
  logic [31:0]   gap_dec;
  logic          accept, out_free, do_half;
  logic [AW+15:0] fs_cmp, thr_cmp;
  logic [63:0]   fs_wide, ss_wide;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != SQ_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign rd_succ = mem_rdata[DW-1:COUNT_WIDTH];
  assign rd_fail = mem_rdata[COUNT_WIDTH-1:0];
  assign cb_inc  = (cb_r == LAST_IDX) ? '0 : cb_r + 1'b1;
  assign gap_dec = gap_r - {16'd0, period_r};
  assign do_half = tripped_r && !stopped_r && (tsf_r > intv_r) && !hot_r;
  assign fs_cmp  = {16'd0, fs_acc_r};
  assign thr_cmp = {{AW{1'b0}}, thr_r};
  assign fs_wide = {{(64-AW){1'b0}}, fs_acc_r};
  assign ss_wide = {{(64-AW){1'b0}}, ss_acc_r};

  cbb_bucket_mem #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .DW(DW),
    .IW(IW)
  ) u_mem (
    .clk(clk),
    .rst_n(rst_n),
    .clear_all(mem_clear),
    .inval_en(mem_inval),
    .inval_addr(mem_inval_addr),
    .wr_en(mem_we),
    .wr_addr(cb_r),
    .wr_data(mem_wdata),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= 16'd1;
      init_r    <= 16'd100;
      mult_r    <= 5'd2;
      timeout_r <= 32'd60000;
      period_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r     <= cfg_wdata[15:0];
        CFG_INIT_INTV: init_r    <= cfg_wdata[15:0];
        CFG_MULT:      mult_r    <= cfg_wdata[4:0];
        CFG_TIMEOUT:   timeout_r <= cfg_wdata;
        CFG_PERIOD:    period_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: if (accept) state_nxt = SQ_PRE;
      SQ_PRE: begin
        case (kind_r)
          REQ_SUCCESS, REQ_QUERY: state_nxt = SQ_EVAL;
          REQ_FAILURE:            state_nxt = SQ_ROTCHK;
          default:                state_nxt = SQ_SUM;
        endcase
      end
      SQ_EVAL:   state_nxt = (kind_r == REQ_SUCCESS) ? SQ_ROTCHK : SQ_SUM;
      SQ_ROTCHK: state_nxt = (tsa_r > {16'd0, period_r}) ? SQ_ROT : SQ_RD;
      SQ_ROT: begin
        if ((gap_dec < {16'd0, period_r}) || (rot_cnt_r + 1'b1 == CNTW'(NUM_BUCKETS)))
          state_nxt = SQ_RD;
      end
      SQ_RD:   state_nxt = SQ_WR;
      SQ_WR:   state_nxt = SQ_SUM;
      SQ_SUM:  if (idx_r == LAST_IDX) state_nxt = SQ_TAIL;
      SQ_TAIL: state_nxt = SQ_DONE;
      SQ_DONE: if (out_free) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt       = kind_r;
    tsa_nxt        = tsa_r;
    tsf_nxt        = tsf_r;
    tsbs_nxt       = tsbs_r;
    intv_nxt       = intv_r;
    stopped_nxt    = stopped_r;
    tripped_nxt    = tripped_r;
    hot_nxt        = hot_r;
    cfc_nxt        = cfc_r;
    cb_nxt         = cb_r;
    idx_nxt        = idx_r;
    gap_nxt        = gap_r;
    rot_cnt_nxt    = rot_cnt_r;
    st_nxt         = st_r;
    ready_nxt      = ready_r;
    acc_en_nxt     = 1'b0;
    fs_acc_nxt     = fs_acc_r;
    ss_acc_nxt     = ss_acc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_clear      = 1'b0;
    mem_inval      = 1'b0;
    mem_inval_addr = cb_inc;
    mem_we         = 1'b0;
    mem_wdata      = mem_rdata;
    mem_rd_addr    = cb_r;

    if (acc_en_r) begin
      fs_acc_nxt = fs_acc_r + AW'(rd_fail);
      ss_acc_nxt = ss_acc_r + AW'(rd_succ);
    end

    case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          kind_nxt  = in_data.req_type;
          tsa_nxt   = sat_add32(tsa_r, in_data.elapsed_ms);
          tsf_nxt   = sat_add32(tsf_r, in_data.elapsed_ms);
          tsbs_nxt  = sat_add32(tsbs_r, in_data.elapsed_ms);
          st_nxt    = ST_CLOSED;
          ready_nxt = 1'b0;
        end
      end
      SQ_PRE: begin
        case (kind_r)
          REQ_SUCCESS: begin
            intv_nxt    = sat_mul32({16'd0, init_r}, mult_r);
            tsbs_nxt    = '0;
            stopped_nxt = 1'b0;
          end
          REQ_RESET: begin
            tripped_nxt = 1'b0;
            hot_nxt     = 1'b0;
            cfc_nxt     = '0;
            mem_clear   = 1'b1;
          end
          default: ;
        endcase
      end
      SQ_EVAL: begin
        if (do_half) begin
          stopped_nxt = (tsbs_r > timeout_r) || stopped_r;
          intv_nxt    = sat_mul32(intv_r, mult_r);
        end
        if (kind_r == REQ_SUCCESS) begin
          cfc_nxt = '0;
          if (do_half) begin
            tripped_nxt = 1'b0;
            hot_nxt     = 1'b0;
            mem_clear   = 1'b1;
          end
        end else begin
          st_nxt    = do_half ? ST_HALF_OPEN : (tripped_r ? ST_OPEN : ST_CLOSED);
          ready_nxt = do_half || !tripped_r;
        end
      end
      SQ_ROTCHK: begin
        gap_nxt     = tsa_r;
        rot_cnt_nxt = '0;
      end
      SQ_ROT: begin
        cb_nxt      = cb_inc;
        mem_inval   = 1'b1;
        gap_nxt     = gap_dec;
        rot_cnt_nxt = rot_cnt_r + 1'b1;
        if (state_nxt == SQ_RD) tsa_nxt = '0;
      end
      SQ_RD: mem_rd_addr = cb_r;
      SQ_WR: begin
        mem_we = 1'b1;
        if (kind_r == REQ_SUCCESS) begin
          mem_wdata = {(rd_succ == CNT_MAX) ? rd_succ : rd_succ + 1'b1, rd_fail};
        end else begin
          mem_wdata = {rd_succ, (rd_fail == CNT_MAX) ? rd_fail : rd_fail + 1'b1};
          if (cfc_r != 16'hFFFF) cfc_nxt = cfc_r + 1'b1;
          tsf_nxt = '0;
        end
      end
      SQ_SUM: begin
        mem_rd_addr = idx_r;
        acc_en_nxt  = 1'b1;
        idx_nxt     = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      SQ_DONE: begin
        if (kind_r == REQ_FAILURE && fs_cmp >= thr_cmp) tripped_nxt = 1'b1;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.state_code = (kind_r == REQ_QUERY) ? st_r :
                                    (!tripped_nxt ? ST_CLOSED :
                                    (hot_r ? ST_HALF_OPEN : ST_OPEN));
          out_data_nxt.ready_res  = ready_r;
          out_data_nxt.failure_total = (fs_wide > 64'h7FFFF) ? SUM_MAX : fs_wide[18:0];
          out_data_nxt.success_total = (ss_wide > 64'h7FFFF) ? SUM_MAX : ss_wide[18:0];
          out_data_nxt.consecutive_failures = cfc_r;
          out_data_nxt.is_tripped = tripped_nxt;
        end
      end
      default: ;
    endcase

    if (state_r == SQ_WR) begin
      fs_acc_nxt = '0;
      ss_acc_nxt = '0;
      idx_nxt    = '0;
    end
    if (state_r == SQ_PRE && kind_r != REQ_SUCCESS && kind_r != REQ_QUERY
        && kind_r != REQ_FAILURE) begin
      fs_acc_nxt = '0;
      ss_acc_nxt = '0;
      idx_nxt    = '0;
    end
    if (state_r == SQ_EVAL && kind_r != REQ_SUCCESS) begin
      fs_acc_nxt = '0;
      ss_acc_nxt = '0;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      kind_r      <= REQ_TIME;
      tsa_r       <= '0;
      tsf_r       <= '0;
      tsbs_r      <= '0;
      intv_r      <= 32'd200;
      stopped_r   <= 1'b0;
      tripped_r   <= 1'b0;
      hot_r       <= 1'b0;
      cfc_r       <= '0;
      cb_r        <= '0;
      idx_r       <= '0;
      rot_cnt_r   <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      tsa_r       <= tsa_nxt;
      tsf_r       <= tsf_nxt;
      tsbs_r      <= tsbs_nxt;
      intv_r      <= intv_nxt;
      stopped_r   <= stopped_nxt;
      tripped_r   <= tripped_nxt;
      hot_r       <= hot_nxt;
      cfc_r       <= cfc_nxt;
      cb_r        <= cb_nxt;
      idx_r       <= idx_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      acc_en_r    <= acc_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r      <= gap_nxt;
    st_r       <= st_nxt;
    ready_r    <= ready_nxt;
    fs_acc_r   <= fs_acc_nxt;
    ss_acc_r   <= ss_acc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == SQ_PRE)
    else $error("accepted transaction did not start the sequencer");

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SQ_ROT |-> rot_cnt_r < CNTW'(NUM_BUCKETS))
    else $error("rotation ran past one lap");

  a_closed_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.is_tripped |-> out_data_r.state_code == ST_CLOSED)
    else $error("untripped breaker reported not closed");

endmodule
